// ===== sv/stable_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue assertion macros
// Shared assertion forms for the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define SPQ_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define SPQ_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W  = 8;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_data;
        logic              empty_flag;
        logic              full_drop;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

// ===== sv/stable_priority_queue.sv =====
// Each result is registered at the output, first in the skid register on a stall.
// One item per cycle while the skid is empty; moving cells shift or load together.
// The output register plus skid stage keeps input open while one result waits.
// Reset clears the entry count and output valids; cell contents are not cleared.
// No clearing pass: the block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue with FIFO order among equal priorities, built as a
// row of shifting cells.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_macros.svh"

module stable_priority_queue
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // entry_data[7:0], entry_priority[15:8]
    input  logic [0:0]  s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_data[7:0], occupancy[12:8], zero[15:13]
    output logic [1:0]  m_axis_tuser   // empty_flag[0], full_drop[1]
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               accept;
    logic               is_deq;
    logic               is_empty;
    logic               is_full;
    ctrl_t              ctrl;
    result_t            result;
    result_t            m_result;
    entry_t             slot [DEPTH];
    logic [DEPTH-1:0]   place;
    logic [DEPTH-1:0]   slot_valid;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_deq   = (s_axis_tuser[0] == CMD_DEQUEUE);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == COUNT_W'(DEPTH));

    assign ctrl.enq            = accept && !is_deq && !is_full;
    assign ctrl.deq            = accept && is_deq && !is_empty;
    assign ctrl.new_entry.data = s_axis_tdata[7:0];
    assign ctrl.new_entry.prio = s_axis_tdata[15:8];

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.enq)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        result.out_data   = ctrl.deq ? slot[0].data : '0;
        result.empty_flag = is_deq && is_empty;
        result.full_drop  = !is_deq && is_full;
        result.occupancy  = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_place;

        assign slot_valid[i] = (count_reg > COUNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_entry = ctrl.new_entry;
            assign left_place = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = slot[i-1];
            assign left_place = place[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = slot[i];
        end
        else
        begin : g_inner
            assign right_entry = slot[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .slot_valid  (slot_valid[i]),
            .left_place  (left_place),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .place       (place[i]),
            .entry       (slot[i])
        );
    end

    spq_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_result  (result),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (m_result)
    );

    assign m_axis_tdata = {3'b000, m_result.occupancy, m_result.out_data};
    assign m_axis_tuser = {m_result.full_drop, m_result.empty_flag};

    `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= COUNT_W'(DEPTH), "entry count exceeds depth")
    `SPQ_ASSERT_NEXT(a_empty_hold, accept && is_deq && is_empty, $stable(count_reg), "empty dequeue changed count")
    `SPQ_ASSERT_NEXT(a_full_hold, accept && !is_deq && is_full, $stable(count_reg), "dropped enqueue changed count")
    `SPQ_ASSERT_NOW(a_stall_has_out, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")
    `SPQ_ASSERT_NOW(a_head_sorted, count_reg >= COUNT_W'(2), slot[0].prio <= slot[1].prio, "head entries out of order")

endmodule

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  ctrl_t  ctrl,
    input  logic   slot_valid,
    input  logic   left_place,
    input  entry_t left_entry,
    input  entry_t right_entry,
    output logic   place,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // empty slots and strictly greater priorities mark the insertion region
    assign place = !slot_valid || (entry_reg.prio > ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.enq && place && left_place)
        begin
            entry_next = left_entry;
        end
        else if (ctrl.enq && place)
        begin
            entry_next = ctrl.new_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/spq_out_buf.sv =====
// ----------------------------------------------------------------------------
// spq_out_buf
// Output register with a skid stage for the result stream.
// ----------------------------------------------------------------------------
module spq_out_buf
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_result,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_valid)
            begin
                out_reg <= in_result;
            end
        end
        else if (in_valid)
        begin
            skid_reg <= in_result;
        end
    end

endmodule
